// File: rtl/assert_macros.svh
// assert_macros.svh - assertion macros shared by the order crossover RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock edge outside reset
`define OCX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression never true outside reset
`define OCX_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define OCX_ASSERT(lbl, clk, rst_n, prop, msg)
`define OCX_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/ocx_pkg.sv
// ocx_pkg.sv - field widths and result status codes of the order crossover engine.
// No dependencies.
package ocx_pkg;

  localparam int FIELD_W  = 16;  // task / node id ports
  localparam int SLICE_W  = 6;   // slice bound ports
  localparam int INDEX_W  = 6;   // gene_index port
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SLICE = 2'd1,
    STATUS_UNFILLED  = 2'd2
  } status_t;

endpackage

// File: rtl/ocx_ram.sv
// ocx_ram.sv - generic single-write, single-read synchronous RAM.
// Read data is registered. No dependencies.
module ocx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/order_crossover_engine_top.sv
// order_crossover_engine_top.sv - order crossover (OX) engine, top level.
// Depends on ocx_pkg, ocx_ram and assert_macros.svh.
`include "assert_macros.svh"

// Order crossover of two parent chromosomes. Each input item carries one
// position of both parents (task id and node id); genes load one item per
// cycle into the parent memories, and items past MAX_GENES are dropped. The
// item with in_last_gene set closes the chromosome and carries the slice
// bounds. The engine then stops taking items (in_stall high) until the whole
// child has been handed to the output register. The slice is checked first:
// a bad slice (begin > end, or end beyond the loaded length) gives a single
// status BAD_SLICE item once the output register is free. Otherwise the
// fill walks the right parent once from slice end + 1; for each right gene
// the kept slice is scanned through the left memory's single read port, one
// left gene per cycle, stopping at the first match. A taken right gene needs
// the full scan of the slice and a skipped one stops at its match. The fill
// ends as soon as all free positions are taken or the right parent is used
// up, and is followed by a settle state. The child then leaves in position
// order, one item per cycle while out_stall is low. Positions the fill never
// reached come out with status UNFILLED and zero ids. The output register
// lets the next chromosome start loading while the final result still waits
// to be taken. Ids are kept at ID_BITS bits internally.
module order_crossover_engine_top
  import ocx_pkg::*;
#(
  parameter int MAX_GENES = 64,
  parameter int ID_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // gene input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FIELD_W-1:0]  in_left_task,
  input  logic [FIELD_W-1:0]  in_left_node,
  input  logic [FIELD_W-1:0]  in_right_task,
  input  logic [FIELD_W-1:0]  in_right_node,
  input  logic [SLICE_W-1:0]  in_slice_begin,
  input  logic [SLICE_W-1:0]  in_slice_end,
  input  logic                in_last_gene,
  // child output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [INDEX_W-1:0]  out_gene_index,
  output logic [FIELD_W-1:0]  out_child_task,
  output logic [FIELD_W-1:0]  out_child_node,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last_result
);

  localparam int AW    = $clog2(MAX_GENES);       // position index
  localparam int CW    = $clog2(MAX_GENES + 1);   // gene count
  localparam int GW    = 2 * ID_BITS;             // {task, node}
  localparam int CMP_W = (CW > SLICE_W) ? CW : SLICE_W;

  typedef enum logic [2:0] {
    ST_LOAD,    // taking genes
    ST_CHECK,   // slice check, prime memory reads
    ST_FILL,    // walk right parent, scan slice per gene
    ST_SETTLE,  // last child write lands before emit reads
    ST_EMIT     // child out in position order
  } state_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;     // genes loaded this run
  logic [CW-1:0]        n_r, n_nxt;             // chromosome length
  logic [SLICE_W-1:0]   b_r, b_nxt;
  logic [SLICE_W-1:0]   e_r, e_nxt;
  logic [AW-1:0]        lp_r, lp_nxt;           // left read ptr / emit position
  logic [AW-1:0]        src_r, src_nxt;         // right parent position
  logic [AW-1:0]        pos_r, pos_nxt;         // next child position to fill
  logic [CW-1:0]        cnt_r, cnt_nxt;         // right genes visited
  logic [MAX_GENES-1:0] filled_r, filled_nxt;   // child positions taken by fill

  logic                 out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]   out_gene_index_r, out_gene_index_nxt;
  logic [FIELD_W-1:0]   out_child_task_r, out_child_task_nxt;
  logic [FIELD_W-1:0]   out_child_node_r, out_child_node_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_last_result_r, out_last_result_nxt;

  // ---------------------------------------------------------------------------
  // Memories. Read addresses come from the _nxt pointers, so each read port
  // always shows the entry at the current pointer register.
  // ---------------------------------------------------------------------------
  logic          par_we;
  logic [AW-1:0] par_wa;
  logic [GW-1:0] left_wd, right_wd, left_q, right_q, child_q;
  logic          child_we;

  assign par_we   = in_valid && !in_stall && (count_r < CW'(MAX_GENES));
  assign par_wa   = count_r[AW-1:0];
  assign left_wd  = {ID_BITS'(in_left_task), ID_BITS'(in_left_node)};
  assign right_wd = {ID_BITS'(in_right_task), ID_BITS'(in_right_node)};

  ocx_ram #(.WIDTH(GW), .DEPTH(MAX_GENES)) u_left_ram (
    .clk     (clk),
    .wr_en   (par_we),
    .wr_addr (par_wa),
    .wr_data (left_wd),
    .rd_addr (lp_nxt),
    .rd_data (left_q)
  );

  ocx_ram #(.WIDTH(GW), .DEPTH(MAX_GENES)) u_right_ram (
    .clk     (clk),
    .wr_en   (par_we),
    .wr_addr (par_wa),
    .wr_data (right_wd),
    .rd_addr (src_nxt),
    .rd_data (right_q)
  );

  ocx_ram #(.WIDTH(GW), .DEPTH(MAX_GENES)) u_child_ram (
    .clk     (clk),
    .wr_en   (child_we),
    .wr_addr (pos_r),
    .wr_data (right_q),
    .rd_addr (lp_nxt),
    .rd_data (child_q)
  );

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x,
                                             input logic [CW-1:0] n);
    logic [CW-1:0] x1;
    x1 = CW'(x) + CW'(1);
    if (x1 == n) begin
      return '0;
    end
    return x + AW'(1);
  endfunction

  logic          in_acc, can_out;
  logic          slice_bad, hit, last_src, scan_end;
  logic          emit_in_slice, pos_in_slice;
  logic [AW-1:0] fill_start, pos_inc;

  assign in_acc    = in_valid && !in_stall;
  assign can_out   = !out_valid_r || !out_stall;
  assign slice_bad = (b_r > e_r) || (CMP_W'(e_r) >= CMP_W'(n_r));
  assign fill_start = wrap_inc(e_r[AW-1:0], n_r);
  assign hit       = left_q[GW-1:ID_BITS] == right_q[GW-1:ID_BITS];
  assign last_src  = (cnt_r + CW'(1)) == n_r;
  assign scan_end  = lp_r == e_r[AW-1:0];
  assign pos_inc   = wrap_inc(pos_r, n_r);
  assign emit_in_slice = (SLICE_W'(lp_r) >= b_r) && (SLICE_W'(lp_r) <= e_r);
  assign pos_in_slice  = (SLICE_W'(pos_r) >= b_r) && (SLICE_W'(pos_r) <= e_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    n_nxt      = n_r;
    b_nxt      = b_r;
    e_nxt      = e_r;
    lp_nxt     = lp_r;
    src_nxt    = src_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    filled_nxt = filled_r;
    child_we   = 1'b0;

    out_valid_nxt       = out_valid_r && out_stall;
    out_gene_index_nxt  = out_gene_index_r;
    out_child_task_nxt  = out_child_task_r;
    out_child_node_nxt  = out_child_node_r;
    out_status_nxt      = out_status_r;
    out_last_result_nxt = out_last_result_r;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_r < CW'(MAX_GENES)) begin
            count_nxt = count_r + CW'(1);
          end
          if (in_last_gene) begin
            n_nxt      = count_nxt;
            b_nxt      = in_slice_begin;
            e_nxt      = in_slice_end;
            count_nxt  = '0;
            filled_nxt = '0;
            state_nxt  = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (slice_bad) begin
          if (can_out) begin
            out_valid_nxt       = 1'b1;
            out_gene_index_nxt  = '0;
            out_child_task_nxt  = '0;
            out_child_node_nxt  = '0;
            out_status_nxt      = STATUS_BAD_SLICE;
            out_last_result_nxt = 1'b1;
            state_nxt           = ST_LOAD;
          end
        end else begin
          lp_nxt  = b_r[AW-1:0];
          src_nxt = fill_start;
          pos_nxt = fill_start;
          cnt_nxt = '0;
          if (fill_start == b_r[AW-1:0]) begin
            lp_nxt    = '0;
            state_nxt = ST_SETTLE;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end

      ST_FILL: begin
        if (hit || scan_end) begin
          // right gene decided: skipped on a slice match, else taken
          src_nxt = wrap_inc(src_r, n_r);
          cnt_nxt = cnt_r + CW'(1);
          lp_nxt  = b_r[AW-1:0];
          if (!hit) begin
            child_we          = 1'b1;
            filled_nxt[pos_r] = 1'b1;
            pos_nxt           = pos_inc;
          end
          if (last_src || (!hit && (pos_inc == b_r[AW-1:0]))) begin
            lp_nxt    = '0;
            state_nxt = ST_SETTLE;
          end
        end else begin
          lp_nxt = lp_r + AW'(1);
        end
      end

      ST_SETTLE: begin
        lp_nxt    = '0;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (can_out) begin
          out_valid_nxt       = 1'b1;
          out_gene_index_nxt  = INDEX_W'(lp_r);
          out_last_result_nxt = (CW'(lp_r) + CW'(1)) == n_r;
          if (emit_in_slice) begin
            out_child_task_nxt = FIELD_W'(left_q[GW-1:ID_BITS]);
            out_child_node_nxt = FIELD_W'(left_q[ID_BITS-1:0]);
            out_status_nxt     = STATUS_OK;
          end else if (filled_r[lp_r]) begin
            out_child_task_nxt = FIELD_W'(child_q[GW-1:ID_BITS]);
            out_child_node_nxt = FIELD_W'(child_q[ID_BITS-1:0]);
            out_status_nxt     = STATUS_OK;
          end else begin
            out_child_task_nxt = '0;
            out_child_node_nxt = '0;
            out_status_nxt     = STATUS_UNFILLED;
          end
          if (out_last_result_nxt) begin
            state_nxt = ST_LOAD;
          end else begin
            lp_nxt = lp_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r               <= n_nxt;
    b_r               <= b_nxt;
    e_r               <= e_nxt;
    lp_r              <= lp_nxt;
    src_r             <= src_nxt;
    pos_r             <= pos_nxt;
    cnt_r             <= cnt_nxt;
    out_gene_index_r  <= out_gene_index_nxt;
    out_child_task_r  <= out_child_task_nxt;
    out_child_node_r  <= out_child_node_nxt;
    out_status_r      <= out_status_nxt;
    out_last_result_r <= out_last_result_nxt;
  end

  assign in_stall        = state_r != ST_LOAD;
  assign out_valid       = out_valid_r;
  assign out_gene_index  = out_gene_index_r;
  assign out_child_task  = out_child_task_r;
  assign out_child_node  = out_child_node_r;
  assign out_status      = out_status_r;
  assign out_last_result = out_last_result_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic bad_misplaced;  // bad slice item that is not the lone final item at zero

  assign bad_misplaced = out_valid_r && (out_status_r == STATUS_BAD_SLICE) &&
                         !(out_last_result_r && (out_gene_index_r == '0));

  `OCX_NEVER(a_fill_outside_slice, clk, rst_n, child_we && pos_in_slice, "fill wrote into slice")
  `OCX_NEVER(a_bad_slice_alone, clk, rst_n, bad_misplaced, "bad slice item not final at zero")
  `OCX_ASSERT(a_fill_bound, clk, rst_n, (state_r == ST_FILL) |-> (cnt_r < n_r), "fill overran")
  `OCX_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(MAX_GENES), "gene count overflow")

endmodule

// File: test/tb_order_crossover_engine_top.sv
// tb_order_crossover_engine_top.sv - self-checking bench for the order crossover engine.
// Depends on ocx_pkg and order_crossover_engine_top; predicts every child item in-bench.
// Covers directed corners, full and overflowing runs, output backpressure, random runs.
module tb_order_crossover_engine_top;
  import ocx_pkg::*;

  localparam int MAX_GENES   = 64;
  localparam int CYCLE_LIMIT = 400000;  // far beyond the slowest legal run
  localparam int DRAIN_WAIT  = 40;      // quiet cycles after the last child item
  localparam int HOLD_LONG   = 300;     // long output hold-off for the pressure test

  // one input item: one position of both parents
  typedef struct packed {
    logic [FIELD_W-1:0] left_task;
    logic [FIELD_W-1:0] left_node;
    logic [FIELD_W-1:0] right_task;
    logic [FIELD_W-1:0] right_node;
    logic [SLICE_W-1:0] slice_begin;
    logic [SLICE_W-1:0] slice_end;
    logic               last_gene;
  } gene_item_t;

  // one child gene as it should leave the block
  typedef struct packed {
    logic [INDEX_W-1:0] gene_index;
    logic [FIELD_W-1:0] child_task;
    logic [FIELD_W-1:0] child_node;
    status_t            status;
    logic               last_result;
  } child_gene_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid;
  logic               in_stall;
  logic [FIELD_W-1:0] in_left_task;
  logic [FIELD_W-1:0] in_left_node;
  logic [FIELD_W-1:0] in_right_task;
  logic [FIELD_W-1:0] in_right_node;
  logic [SLICE_W-1:0] in_slice_begin;
  logic [SLICE_W-1:0] in_slice_end;
  logic               in_last_gene;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [INDEX_W-1:0] out_gene_index;
  logic [FIELD_W-1:0] out_child_task;
  logic [FIELD_W-1:0] out_child_node;
  logic [STATUS_W-1:0] out_status;
  logic               out_last_result;

  logic               hold_active = 1'b0;  // long receiver hold-off in progress

  // bench copy of the parent memories and the load counter
  logic [FIELD_W-1:0] left_task_mem  [MAX_GENES];
  logic [FIELD_W-1:0] left_node_mem  [MAX_GENES];
  logic [FIELD_W-1:0] right_task_mem [MAX_GENES];
  logic [FIELD_W-1:0] right_node_mem [MAX_GENES];
  int                 loaded_genes = 0;

  child_gene_t        child_genes_due[$];

  int send_idle_max = 3;
  int sink_idle_max = 3;
  int sink_wait     = 0;
  int cycle_count   = 0;
  int fail_count    = 0;
  int genes_sent    = 0;
  int runs_sent     = 0;
  int bad_slices    = 0;
  int unfilled_seen = 0;
  int results_seen  = 0;

  order_crossover_engine_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_task    (in_left_task),
    .in_left_node    (in_left_node),
    .in_right_task   (in_right_task),
    .in_right_node   (in_right_node),
    .in_slice_begin  (in_slice_begin),
    .in_slice_end    (in_slice_end),
    .in_last_gene    (in_last_gene),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_gene_index  (out_gene_index),
    .out_child_task  (out_child_task),
    .out_child_node  (out_child_node),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d child items still due", cycle_count,
               child_genes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Load one accepted item into the bench memories; on the closing item work out
  // the whole child and queue it in position order.
  task automatic load_and_cross(input gene_item_t g);
    logic [FIELD_W-1:0] c_task [MAX_GENES];
    logic [FIELD_W-1:0] c_node [MAX_GENES];
    bit                 filled [MAX_GENES];
    child_gene_t        r;
    int                 n, b, e, pos, src, k, p;
    bit                 in_slice;
    if (loaded_genes < MAX_GENES) begin
      left_task_mem[loaded_genes]  = g.left_task;
      left_node_mem[loaded_genes]  = g.left_node;
      right_task_mem[loaded_genes] = g.right_task;
      right_node_mem[loaded_genes] = g.right_node;
      loaded_genes++;
    end
    if (!g.last_gene) return;

    n = loaded_genes;
    b = int'(g.slice_begin);
    e = int'(g.slice_end);
    loaded_genes = 0;
    runs_sent++;

    if (b > e || e >= n) begin
      // bad slice: a single error item closes the run
      r.gene_index  = '0;
      r.child_task  = '0;
      r.child_node  = '0;
      r.status      = STATUS_BAD_SLICE;
      r.last_result = 1'b1;
      child_genes_due = {child_genes_due, r};
      bad_slices++;
      return;
    end

    for (k = 0; k < MAX_GENES; k++) begin
      filled[k] = 1'b0;
      c_task[k] = '0;
      c_node[k] = '0;
    end
    for (k = b; k <= e; k++) begin
      c_task[k] = left_task_mem[k];
      c_node[k] = left_node_mem[k];
      filled[k] = 1'b1;
    end

    // one wrapping pass over the right parent, skipping task ids held by the slice
    pos = (e + 1) % n;
    src = pos;
    for (k = 0; k < n && pos != b; k++) begin
      in_slice = 1'b0;
      for (p = b; p <= e; p++)
        if (left_task_mem[p] == right_task_mem[src]) in_slice = 1'b1;
      if (!in_slice) begin
        c_task[pos] = right_task_mem[src];
        c_node[pos] = right_node_mem[src];
        filled[pos] = 1'b1;
        pos = (pos + 1) % n;
      end
      src = (src + 1) % n;
    end

    for (k = 0; k < n; k++) begin
      r.gene_index  = k[INDEX_W-1:0];
      r.child_task  = filled[k] ? c_task[k] : '0;
      r.child_node  = filled[k] ? c_node[k] : '0;
      r.status      = filled[k] ? STATUS_OK : STATUS_UNFILLED;
      r.last_result = (k == n - 1);
      if (!filled[k]) unfilled_seen++;
      child_genes_due = {child_genes_due, r};
    end
  endtask

  // Offer one item after a random gap and hold it until taken. in_valid stays high
  // on return so back-to-back items never drop it; drop_input lowers it.
  task automatic send_gene(input gene_item_t g);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_left_task   <= g.left_task;
    in_left_node   <= g.left_node;
    in_right_task  <= g.right_task;
    in_right_node  <= g.right_node;
    in_slice_begin <= g.slice_begin;
    in_slice_end   <= g.slice_end;
    in_last_gene   <= g.last_gene;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    genes_sent++;
    load_and_cross(g);
  endtask

  // lowers in_valid and lets one edge pass before anything else drives it
  task automatic drop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic gene_item_t mk_gene(input logic [FIELD_W-1:0] lt, input logic [FIELD_W-1:0] ln,
                                         input logic [FIELD_W-1:0] rt, input logic [FIELD_W-1:0] rn,
                                         input int b, input int e, input bit last);
    gene_item_t g;
    g.left_task   = lt;
    g.left_node   = ln;
    g.right_task  = rt;
    g.right_node  = rn;
    g.slice_begin = b[SLICE_W-1:0];
    g.slice_end   = e[SLICE_W-1:0];
    g.last_gene   = last;
    return g;
  endfunction

  // n items with random ids; pool > 0 draws task ids from 0..pool-1 so that
  // right genes collide with the slice often
  task automatic send_chromosome(input int n, input int b, input int e, input int pool);
    gene_item_t g;
    int i;
    for (i = 0; i < n; i++) begin
      g.left_task   = FIELD_W'(pool > 0 ? $urandom_range(0, pool - 1) : $urandom);
      g.right_task  = FIELD_W'(pool > 0 ? $urandom_range(0, pool - 1) : $urandom);
      g.left_node   = FIELD_W'($urandom);
      g.right_node  = FIELD_W'($urandom);
      g.last_gene   = (i == n - 1);
      g.slice_begin = g.last_gene ? b[SLICE_W-1:0] : SLICE_W'($urandom);
      g.slice_end   = g.last_gene ? e[SLICE_W-1:0] : SLICE_W'($urandom);
      send_gene(g);
    end
  endtask

  // mostly legal slices, the rest reversed or running past the loaded length
  task automatic random_slice(input int n, output int b, output int e);
    if ($urandom_range(0, 99) < 85) begin
      b = $urandom_range(0, n - 1);
      e = $urandom_range(b, n - 1);
    end else if (n >= MAX_GENES || $urandom_range(0, 1)) begin
      b = $urandom_range(1, 63);
      e = $urandom_range(0, b - 1);
    end else begin
      e = $urandom_range(n, 63);
      b = $urandom_range(0, e);
    end
  endtask

  task automatic random_pool(output int pool);
    pool = $urandom_range(0, 1) ? $urandom_range(2, 8) : 0;
  endtask

  // receiver hold-off counted here, apart from the per-item gaps
  task automatic hold_output(input int cycles);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active <= 1'b0;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    child_gene_t exp;
    bit          taken;
    taken = rst_n && out_valid && !out_stall;
    if (taken) begin
      results_seen++;
      if (child_genes_due.size() == 0) begin
        $error("child item with nothing due: index %0d task %0h status %0d",
               out_gene_index, out_child_task, out_status);
        fail_count++;
      end else begin
        exp = child_genes_due.pop_front();
        if (out_gene_index !== exp.gene_index) begin
          $error("gene_index: expected %0d, got %0d", exp.gene_index, out_gene_index);
          fail_count++;
        end
        if (out_child_task !== exp.child_task) begin
          $error("child_task: expected %0h, got %0h", exp.child_task, out_child_task);
          fail_count++;
        end
        if (out_child_node !== exp.child_node) begin
          $error("child_node: expected %0h, got %0h", exp.child_node, out_child_node);
          fail_count++;
        end
        if (out_status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, out_status);
          fail_count++;
        end
        if (out_last_result !== exp.last_result) begin
          $error("last_result: expected %0b, got %0b", exp.last_result, out_last_result);
          fail_count++;
        end
      end
      sink_wait = $urandom_range(0, sink_idle_max);
    end
    if (hold_active) begin
      out_stall <= 1'b1;
    end else if (sink_wait > 0) begin
      out_stall <= 1'b1;
      sink_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Corner cases by hand: one-gene run, full slice, both kinds of bad slice with
  // extreme bounds, a fill that runs dry, repeated right task ids.
  task automatic test_directed_cases();
    // single gene, all ones
    send_gene(mk_gene('1, '1, '1, '1, 0, 0, 1'b1));
    // two genes, slice covers everything, no fill
    send_gene(mk_gene('0, '0, '1, '1, 63, 63, 1'b0));
    send_gene(mk_gene('0, '0, '1, '0, 0, 1, 1'b1));
    // begin past end
    send_gene(mk_gene(16'h0001, 16'h0101, 16'h0002, 16'h0202, 0, 0, 1'b0));
    send_gene(mk_gene(16'h0003, 16'h0303, 16'h0004, 16'h0404, 0, 0, 1'b0));
    send_gene(mk_gene(16'h0005, 16'h0505, 16'h0006, 16'h0606, 2, 1, 1'b1));
    // end beyond loaded length, top bounds
    send_gene(mk_gene(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 0, 0, 1'b0));
    send_gene(mk_gene(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 63, 63, 1'b1));
    send_gene(mk_gene(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 0, 0, 1'b0));
    send_gene(mk_gene(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 0, 0, 1'b0));
    send_gene(mk_gene(16'hffff, 16'h0000, 16'h0000, 16'hffff, 0, 63, 1'b1));
    // every right task id sits in the slice: positions 3, 4 and 0 stay empty
    send_gene(mk_gene(16'd10, 16'd100, 16'd20, 16'd200, 0, 0, 1'b0));
    send_gene(mk_gene(16'd20, 16'd101, 16'd30, 16'd201, 0, 0, 1'b0));
    send_gene(mk_gene(16'd30, 16'd102, 16'd20, 16'd202, 0, 0, 1'b0));
    send_gene(mk_gene(16'd40, 16'd103, 16'd30, 16'd203, 0, 0, 1'b0));
    send_gene(mk_gene(16'd50, 16'd104, 16'd20, 16'd204, 1, 2, 1'b1));
    // one right task id repeated: each copy is taken again
    send_gene(mk_gene(16'd1, 16'd11, 16'd7, 16'd71, 0, 0, 1'b0));
    send_gene(mk_gene(16'd2, 16'd12, 16'd7, 16'd72, 0, 0, 1'b0));
    send_gene(mk_gene(16'd3, 16'd13, 16'd7, 16'd73, 0, 0, 1'b0));
    send_gene(mk_gene(16'd4, 16'd14, 16'd7, 16'd74, 0, 0, 1'b0));
    send_gene(mk_gene(16'd5, 16'd15, 16'd7, 16'd75, 2, 2, 1'b1));
    drop_input();
  endtask

  // Largest chromosome, then two past the store size: the extra items and the
  // closing item's own genes are dropped.
  task automatic test_full_and_overflow();
    send_chromosome(MAX_GENES, MAX_GENES - 1, MAX_GENES - 1, 0);
    send_chromosome(MAX_GENES + 2, 10, 20, 6);
    send_chromosome(MAX_GENES, 0, MAX_GENES - 1, 0);
    drop_input();
  endtask

  // Receiver holds off for a long stretch while the sender keeps going, so the
  // output register fills and in_stall backs up the input.
  task automatic test_output_backpressure();
    int b, e, pool, i, n;
    fork
      hold_output(HOLD_LONG);
    join_none
    for (i = 0; i < 4; i++) begin
      n = $urandom_range(3, 9);
      random_slice(n, b, e);
      random_pool(pool);
      send_chromosome(n, b, e, pool);
    end
    drop_input();
  endtask

  // Random chromosomes, mostly short; some stretches run with no gaps on either side.
  task automatic test_random_chromosomes(input int gene_budget);
    int b, e, pool, n, start;
    start = genes_sent;
    while (genes_sent - start < gene_budget) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) begin
        send_idle_max = 0;
        sink_idle_max = 0;
      end else begin
        send_idle_max = 3;
        sink_idle_max = 3;
      end
      random_slice(n, b, e);
      random_pool(pool);
      send_chromosome(n, b, e, pool);
    end
    send_idle_max = 3;
    sink_idle_max = 3;
    drop_input();
  endtask

  initial begin
    in_valid       <= 1'b0;
    in_left_task   <= '0;
    in_left_node   <= '0;
    in_right_task  <= '0;
    in_right_node  <= '0;
    in_slice_begin <= '0;
    in_slice_end   <= '0;
    in_last_gene   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_full_and_overflow();
    test_output_backpressure();
    test_random_chromosomes(120);

    // drain, then give the block time to show any stray item
    while (child_genes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d genes in %0d chromosomes (%0d bad slices), checked %0d child items",
             genes_sent, runs_sent, bad_slices, results_seen);
    $display("unfilled positions predicted: %0d, mismatches: %0d", unfilled_seen, fail_count);
    if (fail_count == 0 && child_genes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
